/* sv/pafl_pkg.sv */
// Shared types, constants and helpers of the per-CPU page free list allocator.
// No dependencies; the interfaces, the top level, pafl_ctrl and pafl_dp import it.
`default_nettype none

package pafl_pkg;

    localparam int CPU_COUNT_DEF = 8;
    localparam int MAX_PAGES_DEF = 32768;

    localparam int PAGE_SHIFT = 12;

    localparam logic [31:0] REGION_START_RST = 32'h0000_0000;
    localparam logic [31:0] REGION_TOP_RST   = 32'h8800_0000;

    // register index, taken from paddr[2]
    localparam logic REG_START = 1'b0;
    localparam logic REG_TOP   = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_FREED = 2'd1,
        ST_OOM   = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic check;
        logic push;
        logic select;
        logic pop;
        logic load;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic chk_ok;
        logic any_avail;
    } t_sts;

    // cpu_id modulo count by repeated subtraction; id is only 3 bits
    function automatic logic [2:0] fold_cpu(input logic [2:0] id, input int unsigned count);
        logic [3:0] r;
        r = {1'b0, id};
        for (int k = 0; k < 8; k++) begin
            if (32'(r) >= count) begin
                r = r - 4'(count);
            end
        end
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

/* sv/pafl_in_if.sv */
// Request channel of the page allocator: valid/ready plus one request item.
// Depends on pafl_pkg.
`default_nettype none

interface pafl_in_if;
    import pafl_pkg::*;

    logic        valid;
    logic        ready;
    logic        cmd;
    logic [2:0]  cpu_id;
    logic [31:0] page_addr;

    modport source (output valid, cmd, cpu_id, page_addr, input ready);
    modport sink   (input valid, cmd, cpu_id, page_addr, output ready);
endinterface

`default_nettype wire

/* sv/pafl_out_if.sv */
// Result channel of the page allocator: valid/ready plus one result item.
// Depends on pafl_pkg for the status type.
`default_nettype none

interface pafl_out_if;
    import pafl_pkg::*;

    logic        valid;
    logic        ready;
    t_status     status;
    logic [31:0] alloc_addr;

    modport source (output valid, status, alloc_addr, input ready);
    modport sink   (input valid, status, alloc_addr, output ready);
endinterface

`default_nettype wire

/* sv/per_cpu_page_free_list_allocator.sv */
// Per-CPU LIFO free-list allocator for 4096-byte pages.
// Request channel i_in (valid/ready): cmd (allocate or free), cpu_id, page_addr.
// Result channel o_out (valid/ready): status and alloc_addr, one result per item.
// APB port: register 0 region_start at 0x0, register 1 region_top at 0x4.
// A free is checked (aligned, region_start <= addr < region_top, slot within
// MAX_PAGES) and pushed on the requester's list; an allocate pops the own list,
// else the lowest-numbered non-empty list, else reports out of memory.
// One item is in work at a time. An accepted free steps through address check,
// link write and load; an accepted allocate through head select, link RAM read
// and load; a rejected free or out of memory goes from check or select straight
// to load. The next item is taken in the cycle after the result is loaded. There
// is one sequencer state per step; the registered link RAM read has its own.
// The output register holds a result while the receiver stalls; the block takes
// the next item meanwhile and holds its result internally until the register
// frees up. Reset (synchronous, active low) empties all lists and restores the
// region registers; link RAM contents need no clearing, so there is no sweep.
// Populate the lists at start-up by issuing frees.
`default_nettype none

module per_cpu_page_free_list_allocator #(
    parameter int CPU_COUNT = pafl_pkg::CPU_COUNT_DEF,
    parameter int MAX_PAGES = pafl_pkg::MAX_PAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pafl_in_if.sink          i_in,
    pafl_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import pafl_pkg::*;

    logic [31:0] r_region_start;
    logic [31:0] r_region_top;
    logic        cfg_we;
    t_ctl        ctl;
    t_sts        sts;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_start <= REGION_START_RST;
            r_region_top   <= REGION_TOP_RST;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_START: r_region_start <= pwdata;
                REG_TOP:   r_region_top   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START: prdata = r_region_start;
            REG_TOP:   prdata = r_region_top;
            default:   prdata = '0;
        endcase
    end

    pafl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    pafl_dp #(
        .CPU_COUNT (CPU_COUNT),
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cpu_id       (i_in.cpu_id),
        .i_page_addr    (i_in.page_addr),
        .i_region_start (r_region_start),
        .i_region_top   (r_region_top),
        .o_status       (o_out.status),
        .o_alloc_addr   (o_out.alloc_addr)
    );

`ifndef SYNTHESIS
    // one item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("item accepted while previous item in work");

    // only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status != ST_ALLOC) |-> (o_out.alloc_addr == 32'h0))
        else $error("nonzero address on non-allocate result");

    // allocated addresses are page aligned
    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ST_ALLOC) |-> (o_out.alloc_addr[11:0] == 12'h0))
        else $error("allocated address not page aligned");
`endif

endmodule

`default_nettype wire

/* sv/pafl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pafl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/pafl_ctrl.sv */
// Sequencer of the page allocator: handshakes and per-request step order.
// Depends on pafl_pkg; drives pafl_dp through t_ctl and reads t_sts.
`default_nettype none

module pafl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output pafl_pkg::t_ctl      o_ctl,
    input  wire pafl_pkg::t_sts i_sts
);
    import pafl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHK  = 6'b000010,
        S_PUSH = 6'b000100,
        S_SEL  = 6'b001000,
        S_POP  = 6'b010000,
        S_RES  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    // result waits in S_RES until the output register is free or being drained
    assign load        = (r_state == S_RES) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_cmd == CMD_FREE) ? S_CHK : S_SEL;
                end
            end
            S_CHK:  n_state = i_sts.chk_ok ? S_PUSH : S_RES;
            S_PUSH: n_state = S_RES;
            S_SEL:  n_state = i_sts.any_avail ? S_POP : S_RES;
            S_POP:  n_state = S_RES;
            S_RES: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_ctl        = '0;
        o_ctl.accept = accept;
        o_ctl.check  = (r_state == S_CHK);
        o_ctl.push   = (r_state == S_PUSH);
        o_ctl.select = (r_state == S_SEL);
        o_ctl.pop    = (r_state == S_POP);
        o_ctl.load   = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* sv/pafl_dp.sv */
// Datapath of the page allocator: list heads, link RAM, address checks and
// the output register. Depends on pafl_pkg and pafl_ram; steered by pafl_ctrl.
`default_nettype none

module pafl_dp #(
    parameter int CPU_COUNT = pafl_pkg::CPU_COUNT_DEF,
    parameter int MAX_PAGES = pafl_pkg::MAX_PAGES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pafl_pkg::t_ctl    i_ctl,
    output pafl_pkg::t_sts         o_sts,
    input  wire logic [2:0]        i_cpu_id,
    input  wire logic [31:0]       i_page_addr,
    input  wire logic [31:0]       i_region_start,
    input  wire logic [31:0]       i_region_top,
    output pafl_pkg::t_status      o_status,
    output logic      [31:0]       o_alloc_addr
);
    import pafl_pkg::*;

    localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int SLOT_W = $clog2(MAX_PAGES);
    localparam int LINK_W = SLOT_W + 1;
    localparam int PN_W   = 32 - PAGE_SHIFT + 1;     // page number plus carry
    localparam logic [PN_W-1:0] CAP = PN_W'(MAX_PAGES);

    logic [CPU_W-1:0]  r_cpu;
    logic [31:0]       r_addr;
    logic [PN_W-1:0]   r_base;
    logic [SLOT_W-1:0] r_slot;
    logic [CPU_W-1:0]  r_sel;
    t_status           r_status;
    logic [31:0]       r_res_addr;
    t_status           r_out_status;
    logic [31:0]       r_out_addr;

    logic              r_head_ok   [CPU_COUNT];
    logic [SLOT_W-1:0] r_head_slot [CPU_COUNT];

    logic [32:0]       base_sum;
    logic [PN_W-1:0]   diff;
    logic              chk_ok;
    logic              found;
    logic [CPU_W-1:0]  sel;
    logic [PN_W-1:0]   addr_sum;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;

    // first page number at or above region_start
    assign base_sum = {1'b0, i_region_start} + 33'h0_0000_0FFF;

    // address check for a free: aligned, inside the region, slot within capacity
    assign diff   = {1'b0, r_addr[31:PAGE_SHIFT]} - r_base;
    assign chk_ok = (r_addr[PAGE_SHIFT-1:0] == '0) && (r_addr >= i_region_start)
                 && (r_addr < i_region_top) && (diff < CAP);

    // own list first, else lowest-numbered non-empty list
    always_comb begin
        found = r_head_ok[r_cpu];
        sel   = r_cpu;
        for (int i = 0; i < CPU_COUNT; i++) begin
            if (!found && r_head_ok[i]) begin
                found = 1'b1;
                sel   = CPU_W'(i);
            end
        end
    end

    assign o_sts.chk_ok    = chk_ok;
    assign o_sts.any_avail = found;

    assign addr_sum  = r_base + PN_W'(r_slot);
    assign ram_wdata = {r_head_ok[r_cpu], r_head_slot[r_cpu]};

    pafl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_PAGES)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.select),
        .i_raddr (r_head_slot[sel]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cpu  <= CPU_W'(fold_cpu(i_cpu_id, CPU_COUNT));
            r_addr <= i_page_addr;
            r_base <= base_sum[32:PAGE_SHIFT];
        end
        if (i_ctl.check) begin
            r_slot     <= diff[SLOT_W-1:0];
            r_status   <= ST_BAD;
            r_res_addr <= '0;
        end
        if (i_ctl.push) begin
            r_status   <= ST_FREED;
            r_res_addr <= '0;
        end
        if (i_ctl.select) begin
            r_sel      <= sel;
            r_slot     <= r_head_slot[sel];
            r_status   <= ST_OOM;
            r_res_addr <= '0;
        end
        if (i_ctl.pop) begin
            r_status   <= ST_ALLOC;
            r_res_addr <= {addr_sum[31-PAGE_SHIFT:0], {PAGE_SHIFT{1'b0}}};
        end
        if (i_ctl.load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_res_addr;
        end
    end

    // head slots are payload; only the valid flags need reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_head_slot[r_cpu] <= r_slot;
        end else if (i_ctl.pop) begin
            r_head_slot[r_sel] <= ram_rdata[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CPU_COUNT; i++) begin
                r_head_ok[i] <= 1'b0;
            end
        end else if (i_ctl.push) begin
            r_head_ok[r_cpu] <= 1'b1;
        end else if (i_ctl.pop) begin
            r_head_ok[r_sel] <= ram_rdata[SLOT_W];
        end
    end

    assign o_status     = r_out_status;
    assign o_alloc_addr = r_out_addr;

endmodule

`default_nettype wire
